/* rtl/core/time_ordered_message_queue_unit_macros.svh */
// Assertion macros for the time-ordered message queue RTL.
`ifndef TIME_ORDERED_MESSAGE_QUEUE_UNIT_MACROS_SVH
`define TIME_ORDERED_MESSAGE_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTH
// Checks a property on every rising edge of clk outside reset.
`define TOMQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks a property on every rising edge of clk, reset included.
`define TOMQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TOMQ_ASSERT(lbl, prop, msg)
`define TOMQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/core/tomq_pkg.sv */
// Types and constants shared by the time-ordered message queue.
`default_nettype none

package tomq_pkg;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 16;
    localparam int TVAL_W   = 32;
    localparam int TIME_W   = 48;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 5;

    localparam int IN_TDATA_W  = ID_W + TVAL_W + TIME_W;              // 96, whole bytes
    localparam int OUT_FIELD_W = ID_W + TIME_W + OCC_W;               // 69
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;         // 72

    // Command codes; only the upper bit separates inserts from takes.
    localparam logic [CMD_W-1:0] CMD_INSERT_ABS   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT_DELAY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TAKE         = 2'd2;
    localparam int               CMD_TAKE_BIT     = 1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_DELIVERED = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_DUE   = 3'd4
    } status_t;

    typedef struct packed {
        logic [TIME_W-1:0] due;
        logic [ID_W-1:0]   id;
    } entry_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic   ins;
        logic   take;
        entry_t item;
    } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/time_ordered_message_queue_unit.sv */
// Time-ordered message queue: a sorted chain of cells holding timed messages.
//
// Usage. Commands arrive on the slave stream (s_*): tuser carries the command
// (absolute insert, delayed insert, take) and tdata the message identifier,
// the time value and the current time. Every command gives exactly one result
// transaction on the master stream (m_*): tuser carries the status and tdata
// the delivered identifier, the due time and the occupancy after the command.
// From acceptance to a valid result, the first register stage holds the due
// time (delay add with saturation), and the second stage updates the cell
// chain and loads the output register. Throughput is one command per cycle
// while results are taken, set by the chain, in which every cell compares the
// new due time with its own and all cells shift together. Reset clears the fill
// count and both valid flags; message storage is not cleared, since cells
// beyond the fill count are never read. When the receiver stalls, the result
// waits in the output register, one more command waits in the first stage and
// s_tready then falls until the result is taken; nothing is lost or repeated.
`default_nettype none
`include "time_ordered_message_queue_unit_macros.svh"

module time_ordered_message_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [15:0] message_id, [47:16] time_value, [95:48] current_time
    input  wire logic [tomq_pkg::IN_TDATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  wire logic [tomq_pkg::CMD_W-1:0]       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [15:0] out_message_id, [63:16] out_due_time, [68:64] occupancy, rest zero
    output logic [tomq_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // [2:0] status
    output logic [tomq_pkg::STATUS_W-1:0]         m_tuser
);
    import tomq_pkg::*;

    localparam int               CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    // Input fields.
    logic [ID_W-1:0]   in_id;
    logic [TVAL_W-1:0] in_tval;
    logic [TIME_W-1:0] in_now;
    logic [TIME_W:0]   delay_sum;
    logic [TIME_W-1:0] in_due;

    assign in_id   = s_tdata[ID_W-1:0];
    assign in_tval = s_tdata[ID_W +: TVAL_W];
    assign in_now  = s_tdata[ID_W+TVAL_W +: TIME_W];

    // Delayed due time saturates at the top of the time range.
    assign delay_sum = {1'b0, in_now} + {{(TIME_W + 1 - TVAL_W){1'b0}}, in_tval};
    always_comb
    begin
        if (s_tuser == CMD_INSERT_ABS)
        begin
            in_due = {{(TIME_W - TVAL_W){1'b0}}, in_tval};
        end
        else if (delay_sum[TIME_W])
        begin
            in_due = {TIME_W{1'b1}};
        end
        else
        begin
            in_due = delay_sum[TIME_W-1:0];
        end
    end

    // First stage registers.
    logic              s1_valid_reg;
    logic              s1_take_reg;
    entry_t            s1_item_reg;
    logic [TIME_W-1:0] s1_now_reg;

    // Output register.
    logic                 out_valid_reg;
    status_t              out_status_reg;
    status_t              out_status_next;
    logic [ID_W-1:0]      out_id_reg;
    logic [ID_W-1:0]      out_id_next;
    logic [TIME_W-1:0]    out_due_reg;
    logic [TIME_W-1:0]    out_due_next;
    logic [OCC_W-1:0]     out_occ_reg;
    logic [OCC_W-1:0]     out_occ_next;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W+OCC_W-1:0] count_ext;

    logic out_free;
    logic s1_fire;
    logic s_fire;

    assign out_free = !out_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_fire   = s_tvalid && s_tready;

    // Cell chain, cell 0 is the head.
    cell_ctl_t ctl;
    entry_t    cell_entry [QUEUE_DEPTH];
    logic      cell_before[QUEUE_DEPTH];
    entry_t    left_entry [QUEUE_DEPTH];
    logic      left_before[QUEUE_DEPTH];
    entry_t    right_entry[QUEUE_DEPTH];
    logic      cell_occ   [QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left_entry[i]  = '0;
            assign left_before[i] = 1'b0;
        end
        else
        begin : g_body
            assign left_entry[i]  = cell_entry[i-1];
            assign left_before[i] = cell_before[i-1];
        end
        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_entry[i] = '0;
        end
        else
        begin : g_inner
            assign right_entry[i] = cell_entry[i+1];
        end
        assign cell_occ[i] = (count_reg > CNT_W'(i));

        tomq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occ         (cell_occ[i]),
            .left_entry  (left_entry[i]),
            .left_before (left_before[i]),
            .right_entry (right_entry[i]),
            .entry       (cell_entry[i]),
            .ins_here    (cell_before[i])
        );
    end

    // Second stage: decide the command against the head and the fill count.
    always_comb
    begin
        ctl.ins         = 1'b0;
        ctl.take        = 1'b0;
        ctl.item        = s1_item_reg;
        count_next      = count_reg;
        out_status_next = ST_INSERTED;
        out_id_next     = '0;
        out_due_next    = '0;
        if (s1_fire)
        begin
            if (!s1_take_reg)
            begin
                if (count_reg >= DEPTH_C)
                begin
                    out_status_next = ST_FULL;
                end
                else
                begin
                    out_status_next = ST_INSERTED;
                    ctl.ins         = 1'b1;
                    count_next      = count_reg + CNT_W'(1);
                end
            end
            else if (count_reg == '0)
            begin
                out_status_next = ST_EMPTY;
            end
            else if (cell_entry[0].due > s1_now_reg)
            begin
                out_status_next = ST_NOT_DUE;
                out_due_next    = cell_entry[0].due;
            end
            else
            begin
                out_status_next = ST_DELIVERED;
                out_id_next     = cell_entry[0].id;
                out_due_next    = cell_entry[0].due;
                ctl.take        = 1'b1;
                count_next      = count_reg - CNT_W'(1);
            end
        end
    end

    // Occupancy is reported modulo the width of the field.
    assign count_ext    = {{OCC_W{1'b0}}, count_next};
    assign out_occ_next = count_ext[OCC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_take_reg      <= s_tuser[CMD_TAKE_BIT];
            s1_item_reg.due  <= in_due;
            s1_item_reg.id   <= in_id;
            s1_now_reg       <= in_now;
        end
        if (s1_fire)
        begin
            out_status_reg <= out_status_next;
            out_id_reg     <= out_id_next;
            out_due_reg    <= out_due_next;
            out_occ_reg    <= out_occ_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, out_occ_reg, out_due_reg, out_id_reg};

    // The fill count never passes the number of cells.
    `TOMQ_ASSERT(a_count_bound, count_reg <= DEPTH_C, "fill count above queue depth")
    // The two front entries stay in due-time order.
    `TOMQ_ASSERT(a_head_sorted, (count_reg >= CNT_W'(2)) |-> (cell_entry[0].due <= cell_entry[1].due), "head entries out of order")
    // A delivery removes exactly one entry.
    `TOMQ_ASSERT(a_take_count, ctl.take |=> (count_reg == $past(count_reg) - CNT_W'(1)), "delivery did not shrink the queue")
    // A rejected insert only happens with every cell occupied.
    `TOMQ_ASSERT(a_full_reject, (s1_fire && out_status_next == ST_FULL) |-> (count_reg == DEPTH_C), "insert rejected below full")

endmodule

`default_nettype wire

/* rtl/core/tomq_cell.sv */
// One storage cell of the sorted chain: holds a message and its due time.
`default_nettype none

module tomq_cell (
    input  wire logic               clk,
    input  wire tomq_pkg::cell_ctl_t ctl,
    input  wire logic               occ,          // cell lies below the fill count
    input  wire tomq_pkg::entry_t   left_entry,
    input  wire logic               left_before,
    input  wire tomq_pkg::entry_t   right_entry,
    output tomq_pkg::entry_t        entry,
    output logic                    ins_here      // new item belongs at or ahead of this cell
);
    import tomq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Strict compare keeps an equal due time behind the older entry.
    assign ins_here = !occ || (ctl.item.due < entry_reg.due);
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctl.ins && ins_here)
        begin
            entry_next = left_before ? left_entry : ctl.item;
        end
        else if (ctl.take)
        begin
            entry_next = right_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire
